@@ src/bhd_pkg.sv @@
// ----------------------------------------------------------------------------
// bhd_pkg
// Shared types, register indexes and codes for the button hold detector.
// ----------------------------------------------------------------------------
package bhd_pkg;

  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned CFG_INDEX_BITS = 3;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [1:0] dir_t;

  localparam dir_t DirNone = 2'd0;
  localparam dir_t DirUp   = 2'd1;
  localparam dir_t DirDown = 2'd2;

  localparam logic [1:0] CmdEvent   = 2'd0;
  localparam logic [1:0] CmdTake    = 2'd1;
  localparam logic [1:0] CmdRestore = 2'd2;
  localparam logic [1:0] CmdUnused  = 2'd3;

  localparam logic [1:0] KindVolume = 2'd0;
  localparam logic [1:0] KindMode   = 2'd1;
  localparam logic [1:0] KindFilm   = 2'd2;
  localparam logic [1:0] KindOther  = 2'd3;

  localparam logic [CFG_INDEX_BITS-1:0] RegHoldGap    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] RegHoldMin    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] RegHoldEvents = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] RegCooldown   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] RegVolumeMid  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] RegSavedMode  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] RegFilmKnown  = 3'd6;

  localparam logic [15:0] HoldGapReset    = 16'd700;
  localparam logic [15:0] HoldMinReset    = 16'd1200;
  localparam logic [7:0]  HoldEventsReset = 8'd4;
  localparam logic [15:0] CooldownReset   = 16'd8000;
  localparam logic [3:0]  VolumeMidReset  = 4'd4;

  localparam logic [7:0] CountMax = 8'd255;

  typedef struct packed {
    logic [15:0] gap_limit;
    logic [15:0] span_min;
    logic [7:0]  press_min;
    logic [15:0] quiet_len;
    logic [3:0]  level_mid;
    logic [7:0]  saved_display_mode;
    logic        lens_tracked;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] event_kind;
    logic [7:0] event_value;
    time_t      time_ms;
  } item_t;

  typedef struct packed {
    logic  hold_fired;
    logic  holding;
    time_t held_ms;
    dir_t  press_direction;
    dir_t  taken_direction;
    logic  mode_was_dirty;
    logic  film_was_dirty;
  } res_t;

endpackage

@@ src/bhd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bhd_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bhd_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bhd_pkg::CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  logic [bhd_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  output bhd_pkg::cfg_t                         cfg_o
);

  bhd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        bhd_pkg::RegHoldGap:    cfg_d.gap_limit          = cfg_data_i;
        bhd_pkg::RegHoldMin:    cfg_d.span_min           = cfg_data_i;
        bhd_pkg::RegHoldEvents: cfg_d.press_min          = cfg_data_i[7:0];
        bhd_pkg::RegCooldown:   cfg_d.quiet_len          = cfg_data_i;
        bhd_pkg::RegVolumeMid:  cfg_d.level_mid          = cfg_data_i[3:0];
        bhd_pkg::RegSavedMode:  cfg_d.saved_display_mode = cfg_data_i[7:0];
        bhd_pkg::RegFilmKnown:  cfg_d.lens_tracked       = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_limit          <= bhd_pkg::HoldGapReset;
      cfg_q.span_min           <= bhd_pkg::HoldMinReset;
      cfg_q.press_min          <= bhd_pkg::HoldEventsReset;
      cfg_q.quiet_len          <= bhd_pkg::CooldownReset;
      cfg_q.level_mid          <= bhd_pkg::VolumeMidReset;
      cfg_q.saved_display_mode <= 8'd0;
      cfg_q.lens_tracked       <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/bhd_engine.sv @@
// ----------------------------------------------------------------------------
// bhd_engine
// Detector state and the single-pass update for one transaction.
// ----------------------------------------------------------------------------
module bhd_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  bhd_pkg::item_t item_i,
  input  bhd_pkg::cfg_t  cfg_i,
  output bhd_pkg::res_t  res_o
);

  logic                 level_known_q, level_known_d;
  logic [7:0]           last_level_q, last_level_d;
  bhd_pkg::dir_t        direction_q, direction_d;
  logic [7:0]           run_count_q, run_count_d;
  bhd_pkg::time_t       run_start_q, run_start_d;
  bhd_pkg::time_t       run_last_q, run_last_d;
  bhd_pkg::time_t       quiet_until_q, quiet_until_d;
  logic                 trigger_q, trigger_d;
  bhd_pkg::dir_t        fired_dir_q, fired_dir_d;
  logic                 mode_chg_q, mode_chg_d;
  logic                 lens_chg_q, lens_chg_d;

  bhd_pkg::dir_t  dir_base, dir_new;
  bhd_pkg::time_t rem, gap, since_start;
  logic           cool, restart, fire;
  logic [7:0]     cnt_base, cnt_inc;

  assign rem         = quiet_until_q - item_i.time_ms;
  assign cool        = (rem != '0) && (rem <= bhd_pkg::time_t'(cfg_i.quiet_len));
  assign gap         = item_i.time_ms - run_last_q;
  assign restart     = (run_count_q == 8'd0) || (gap > bhd_pkg::time_t'(cfg_i.gap_limit));
  assign since_start = item_i.time_ms - run_start_q;
  assign cnt_base    = restart ? 8'd0 : run_count_q;
  assign cnt_inc     = (cnt_base < bhd_pkg::CountMax) ? cnt_base + 8'd1 : cnt_base;

  always_comb begin
    dir_base = (run_count_q == 8'd0) ? bhd_pkg::DirNone : direction_q;
    if (!level_known_q) begin
      dir_new = bhd_pkg::DirNone;
    end else if (item_i.event_value > last_level_q) begin
      dir_new = bhd_pkg::DirUp;
    end else if (item_i.event_value < last_level_q) begin
      dir_new = bhd_pkg::DirDown;
    end else if (item_i.event_value == 8'd0) begin
      dir_new = bhd_pkg::DirDown;
    end else if (item_i.event_value > {4'd0, cfg_i.level_mid}) begin
      dir_new = bhd_pkg::DirUp;
    end else begin
      dir_new = dir_base;
    end
  end

  assign fire = !cool && (cnt_inc >= cfg_i.press_min)
              && ((restart ? '0 : since_start) >= bhd_pkg::time_t'(cfg_i.span_min))
              && (dir_new != bhd_pkg::DirNone);

  always_comb begin
    level_known_d = level_known_q;
    last_level_d  = last_level_q;
    direction_d   = direction_q;
    run_count_d   = run_count_q;
    run_start_d   = run_start_q;
    run_last_d    = run_last_q;
    quiet_until_d = quiet_until_q;
    trigger_d     = trigger_q;
    fired_dir_d   = fired_dir_q;
    mode_chg_d    = mode_chg_q;
    lens_chg_d    = lens_chg_q;
    res_o         = '0;

    case (item_i.cmd)
      bhd_pkg::CmdEvent: begin
        case (item_i.event_kind)
          bhd_pkg::KindVolume: begin
            direction_d   = dir_new;
            last_level_d  = item_i.event_value;
            level_known_d = 1'b1;
            if (!cool) begin
              run_last_d = item_i.time_ms;
              if (restart) begin
                run_start_d = item_i.time_ms;
              end
              if (fire) begin
                trigger_d     = 1'b1;
                fired_dir_d   = dir_new;
                quiet_until_d = item_i.time_ms + bhd_pkg::time_t'(cfg_i.quiet_len);
                run_count_d   = 8'd0;
              end else begin
                run_count_d = cnt_inc;
              end
            end
            res_o.hold_fired = fire;
            res_o.holding    = !fire && !cool;
            res_o.held_ms    = (restart && !cool) ? '0 : since_start;
          end
          bhd_pkg::KindMode: begin
            if ((cfg_i.saved_display_mode != 8'd0)
                && (item_i.event_value != cfg_i.saved_display_mode)) begin
              mode_chg_d = 1'b1;
            end
          end
          bhd_pkg::KindFilm: begin
            if (cfg_i.lens_tracked) begin
              lens_chg_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      bhd_pkg::CmdTake: begin
        res_o.taken_direction = trigger_q ? fired_dir_q : bhd_pkg::DirNone;
        trigger_d = 1'b0;
      end
      bhd_pkg::CmdRestore: begin
        res_o.mode_was_dirty = mode_chg_q;
        res_o.film_was_dirty = lens_chg_q;
        mode_chg_d    = 1'b0;
        lens_chg_d    = 1'b0;
        last_level_d  = {4'd0, cfg_i.level_mid};
        level_known_d = 1'b1;
        run_count_d   = 8'd0;
      end
      default: ;
    endcase
    res_o.press_direction = direction_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_known_q <= 1'b0;
      last_level_q  <= 8'd0;
      direction_q   <= bhd_pkg::DirNone;
      run_count_q   <= 8'd0;
      run_start_q   <= '0;
      run_last_q    <= '0;
      quiet_until_q <= '0;
      trigger_q     <= 1'b0;
      fired_dir_q   <= bhd_pkg::DirNone;
      mode_chg_q    <= 1'b0;
      lens_chg_q    <= 1'b0;
    end else if (en_i) begin
      level_known_q <= level_known_d;
      last_level_q  <= last_level_d;
      direction_q   <= direction_d;
      run_count_q   <= run_count_d;
      run_start_q   <= run_start_d;
      run_last_q    <= run_last_d;
      quiet_until_q <= quiet_until_d;
      trigger_q     <= trigger_d;
      fired_dir_q   <= fired_dir_d;
      mode_chg_q    <= mode_chg_d;
      lens_chg_q    <= lens_chg_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    trigger_q |-> (fired_dir_q != bhd_pkg::DirNone))
    else $error("latched trigger without a direction");

endmodule

@@ src/button_hold_detector.sv @@
// ----------------------------------------------------------------------------
// button_hold_detector
// Long-press detector for timestamped button events with take and restore.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  cmd, event_kind, event_value, time_ms
//   out      output     out_valid_o/out_ready_i hold_fired .. film_was_dirty
//   cfg      input      cfg_we_i               cfg_index_i, cfg_data_i
//
// One transaction per cycle sustained while results are taken; an accepted
// transaction waits in the input register, which feeds the update logic, and
// its result loads into the result register once that register is free.
// Reset clears the detector state and loads register defaults.
// A stalled result holds its register; the input stage keeps accepting while
// the result register is free or being taken.
// ----------------------------------------------------------------------------
module button_hold_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bhd_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [bhd_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          cmd_i,
  input  logic [1:0]                          event_kind_i,
  input  logic [7:0]                          event_value_i,
  input  bhd_pkg::time_t                      time_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hold_fired_o,
  output logic                                holding_o,
  output bhd_pkg::time_t                      held_ms_o,
  output bhd_pkg::dir_t                       press_direction_o,
  output bhd_pkg::dir_t                       taken_direction_o,
  output logic                                mode_was_dirty_o,
  output logic                                film_was_dirty_o
);

  bhd_pkg::cfg_t  cfg;
  bhd_pkg::item_t item_q;
  bhd_pkg::res_t  res, res_q;
  logic           in_valid_q, in_valid_d;
  logic           out_valid_q, out_valid_d;
  logic           advance;

  bhd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bhd_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_valid_d  = (in_valid_i && in_ready_o) || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.cmd         <= cmd_i;
      item_q.event_kind  <= event_kind_i;
      item_q.event_value <= event_value_i;
      item_q.time_ms     <= time_ms_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign hold_fired_o      = res_q.hold_fired;
  assign holding_o         = res_q.holding;
  assign held_ms_o         = res_q.held_ms;
  assign press_direction_o = res_q.press_direction;
  assign taken_direction_o = res_q.taken_direction;
  assign mode_was_dirty_o  = res_q.mode_was_dirty;
  assign film_was_dirty_o  = res_q.film_was_dirty;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with an empty result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && hold_fired_o) |-> (!holding_o && press_direction_o != bhd_pkg::DirNone))
    else $error("fired result inconsistent");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && taken_direction_o != bhd_pkg::DirNone)
      |-> (!hold_fired_o && !holding_o && !mode_was_dirty_o && !film_was_dirty_o))
    else $error("take result carries event fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (mode_was_dirty_o || film_was_dirty_o))
      |-> (!hold_fired_o && !holding_o && held_ms_o == '0))
    else $error("restore result carries volume fields");

endmodule
